@@ rtl/hks_pkg.sv @@
// Package: shared types and constants for the HID key report scheduler.
package hks_pkg;
    localparam int unsigned QUEUE_DEPTH_DEF = 8;
    localparam logic [15:0] HOLD_LIMIT_DEF = 16'd3000;
    localparam logic [7:0]  TAP_TIME_DEF   = 8'd20;

    localparam logic [2:0] ACT_POLL    = 3'd0;
    localparam logic [2:0] ACT_HOLD    = 3'd1;
    localparam logic [2:0] ACT_TAP     = 3'd2;
    localparam logic [2:0] ACT_REL_OWN = 3'd3;
    localparam logic [2:0] ACT_REL_ALL = 3'd4;
    localparam logic [2:0] ACT_READY   = 3'd5;

    localparam logic [0:0] CFG_HOLD_LIMIT = 1'd0;
    localparam logic [0:0] CFG_TAP_TIME   = 1'd1;

    localparam logic [1:0] RID_KBD = 2'd1;
    localparam logic [1:0] RID_CON = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [7:0]  key_usage;
        logic [7:0]  key_modifier;
        logic [7:0]  consumer_code;
        logic [15:0] owner_id;
        logic        ready_level;
    } t_req;

    typedef struct packed {
        logic        report_valid;
        logic [1:0]  report_id;
        logic [3:0]  report_length;
        logic [7:0]  report_first_byte;
        logic [7:0]  report_usage_byte;
        logic        request_accepted;
        logic        forced_release;
        logic [15:0] dropped_total;
        logic [15:0] forced_total;
    } t_rsp;

    typedef struct packed {
        logic        is_tap;
        logic [7:0]  usage;
        logic [7:0]  modifier;
        logic [7:0]  consumer;
        logic [15:0] owner;
    } t_entry;

    // Per-cycle command to the cell chain
    typedef struct packed {
        logic   push;     // load entry into cell at count position
        logic   pop;      // shift all cells toward the head
        logic   flush;    // clear all valid bits
        logic   purge;    // one compaction step
        logic   all;      // purge every hold
        logic [15:0] owner;
        t_entry data;
    } t_qcmd;
endpackage

@@ rtl/hks_if.sv @@
// Interfaces: valid/ready request, response and configuration channels.
interface hks_req_if;
    import hks_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hks_rsp_if;
    import hks_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hks_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/hks_cell.sv @@
// Queue cell: one entry with valid bit, loads from its upstream neighbor.
module hks_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hks_pkg::t_qcmd  i_cmd,
    input  logic            i_load_here,
    input  logic            i_nxt_valid,
    input  hks_pkg::t_entry i_nxt_data,
    input  logic            i_purge_shift,
    output logic            o_valid,
    output logic            o_kill,
    output hks_pkg::t_entry o_data
);
    import hks_pkg::*;
    logic   r_valid;
    t_entry r_data;

    // Entry is a hold matching the purge condition
    assign o_kill  = r_valid && !r_data.is_tap && (i_cmd.all || r_data.owner == i_cmd.owner);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_valid <= 1'b0;
        end else if (i_cmd.pop || (i_cmd.purge && i_purge_shift)) begin
            r_valid <= i_nxt_valid;
        end else if (i_load_here) begin
            r_valid <= 1'b1;
        end
        if (i_cmd.pop || (i_cmd.purge && i_purge_shift)) begin
            r_data <= i_nxt_data;
        end else if (i_load_here) begin
            r_data <= i_cmd.data;
        end
    end
endmodule

@@ rtl/hks_queue.sv @@
// Request queue: a row of cells, head at cell 0, compaction one removal per cycle.
module hks_queue #(
    parameter int unsigned DEPTH = hks_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hks_pkg::t_qcmd  i_cmd,
    output logic            o_full,
    output logic            o_empty,
    output logic            o_kill_any,
    output hks_pkg::t_entry o_head
);
    import hks_pkg::*;
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_kill;
    logic [DEPTH-1:0] w_shift;
    logic [DEPTH-1:0] w_load;
    t_entry           w_data [DEPTH];

    // Shift from the first killed cell upward
    always_comb begin
        w_shift[0] = w_kill[0];
        for (int i = 1; i < DEPTH; i++) begin
            w_shift[i] = w_shift[i-1] || w_kill[i];
        end
        for (int i = 0; i < DEPTH; i++) begin
            w_load[i] = i_cmd.push && !w_valid[i] && (i == 0 || w_valid[i-1]);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   w_nv;
        t_entry w_nd;
        if (g == DEPTH - 1) begin : g_last
            assign w_nv = 1'b0;
            assign w_nd = w_data[g];
        end else begin : g_mid
            assign w_nv = w_valid[g+1];
            assign w_nd = w_data[g+1];
        end
        hks_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_load_here  (w_load[g]),
            .i_nxt_valid  (w_nv),
            .i_nxt_data   (w_nd),
            .i_purge_shift(w_shift[g]),
            .o_valid      (w_valid[g]),
            .o_kill       (w_kill[g]),
            .o_data       (w_data[g])
        );
    end

    assign o_full     = w_valid[DEPTH-1];
    assign o_empty    = !w_valid[0];
    assign o_kill_any = |w_kill;
    assign o_head     = w_data[0];
endmodule

@@ rtl/hid_key_report_scheduler.sv @@
// Top level: HID key report scheduler with control sequencer and queue cells.
// Sequencing: an accepted item's result is offered in the cycle after it is taken, except for release
// all and for release owner when the held key is not that owner's; these pass through the purge state,
// which removes one queued hold per step until no matching hold is left, and then offer the result.
// One item at a time; the next item is accepted the cycle after the result transfer.
// Reset (i_rst_n low, synchronous) clears queue, key state and counters; 3000 ms / 20 ms.
module hid_key_report_scheduler #(
    parameter int unsigned QUEUE_DEPTH = hks_pkg::QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hks_req_if.sink   req,
    hks_rsp_if.source rsp,
    hks_cfg_if.sink   cfg
);
    import hks_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_PURGE, ST_OUT} t_state;

    t_state      r_state;
    t_req        r_req;
    t_rsp        r_rsp;
    logic [15:0] r_hold_limit;
    logic [7:0]  r_tap_time;
    logic        r_link;
    logic        r_held_v, r_held_c, r_tap_v, r_tap_c, r_up_v, r_up_c;
    logic [15:0] r_held_own;
    logic [31:0] r_held_dl, r_tap_dl;
    logic [15:0] r_drops, r_forces;

    logic   w_full, w_empty, w_kill_any;
    t_entry w_head;
    t_qcmd  w_cmd;
    logic   w_acc;
    logic [31:0] w_hd, w_td;

    assign req.ready = (r_state == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = (r_state == ST_OUT);
    assign w_acc = req.valid && req.ready;
    assign w_hd  = req.data.now_ms - r_held_dl;
    assign w_td  = req.data.now_ms - r_tap_dl;

    always_comb begin
        w_cmd = '0;
        w_cmd.owner = (r_state == ST_PURGE) ? r_req.owner_id : req.data.owner_id;
        w_cmd.all   = (r_state == ST_PURGE) ? (r_req.action == ACT_REL_ALL) : 1'b0;
        w_cmd.data.is_tap   = (req.data.action == ACT_TAP);
        w_cmd.data.usage    = req.data.key_usage;
        w_cmd.data.modifier = req.data.key_modifier;
        w_cmd.data.consumer = req.data.consumer_code;
        w_cmd.data.owner    = (req.data.action == ACT_TAP) ? 16'd0 : req.data.owner_id;
        if (r_state == ST_PURGE) begin
            w_cmd.purge = 1'b1;
        end else if (w_acc) begin
            case (req.data.action)
                ACT_POLL: w_cmd.pop = !r_up_v && !(r_held_v && !w_hd[31]) && !r_tap_v
                                      && !w_empty && !r_held_v;
                ACT_HOLD, ACT_TAP: w_cmd.push = r_link && !w_full;
                ACT_READY: w_cmd.flush = r_link && !req.data.ready_level;
                default: ;
            endcase
        end
    end

    hks_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_full    (w_full),
        .o_empty   (w_empty),
        .o_kill_any(w_kill_any),
        .o_head    (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hold_limit <= HOLD_LIMIT_DEF;
            r_tap_time <= TAP_TIME_DEF;
            r_link <= 1'b0;
            r_held_v <= 1'b0; r_held_c <= 1'b0; r_held_own <= '0; r_held_dl <= '0;
            r_tap_v <= 1'b0; r_tap_c <= 1'b0; r_tap_dl <= '0;
            r_up_v <= 1'b0; r_up_c <= 1'b0;
            r_drops <= '0; r_forces <= '0;
        end else begin
            if (cfg.valid) begin
                case (cfg.index)
                    CFG_HOLD_LIMIT: r_hold_limit <= cfg.wdata;
                    CFG_TAP_TIME:   r_tap_time <= cfg.wdata[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: if (w_acc) begin
                    r_req <= req.data;
                    r_rsp <= '0;
                    r_state <= ST_OUT;
                    case (req.data.action)
                        ACT_POLL: begin
                            if (r_up_v) begin
                                r_up_v <= 1'b0;
                                r_rsp.report_valid <= 1'b1;
                                r_rsp.report_id <= r_up_c ? RID_CON : RID_KBD;
                                r_rsp.report_length <= r_up_c ? 4'd1 : 4'd8;
                            end else if (r_held_v && !w_hd[31]) begin
                                r_held_v <= 1'b0; r_held_own <= '0;
                                r_rsp.report_valid <= 1'b1;
                                r_rsp.report_id <= r_held_c ? RID_CON : RID_KBD;
                                r_rsp.report_length <= r_held_c ? 4'd1 : 4'd8;
                                r_rsp.forced_release <= 1'b1;
                                if (r_forces != 16'hFFFF) r_forces <= r_forces + 16'd1;
                            end else if (r_tap_v) begin
                                if (!w_td[31]) begin
                                    r_tap_v <= 1'b0;
                                    r_rsp.report_valid <= 1'b1;
                                    r_rsp.report_id <= r_tap_c ? RID_CON : RID_KBD;
                                    r_rsp.report_length <= r_tap_c ? 4'd1 : 4'd8;
                                end
                            end else if (!w_empty) begin
                                r_rsp.report_valid <= 1'b1;
                                if (r_held_v) begin
                                    r_held_v <= 1'b0; r_held_own <= '0;
                                    r_rsp.report_id <= r_held_c ? RID_CON : RID_KBD;
                                    r_rsp.report_length <= r_held_c ? 4'd1 : 4'd8;
                                end else begin
                                    if (w_head.consumer != 8'd0) begin
                                        r_rsp.report_id <= RID_CON;
                                        r_rsp.report_length <= 4'd1;
                                        r_rsp.report_first_byte <= w_head.consumer;
                                    end else begin
                                        r_rsp.report_id <= RID_KBD;
                                        r_rsp.report_length <= 4'd8;
                                        r_rsp.report_first_byte <= w_head.modifier;
                                        r_rsp.report_usage_byte <= w_head.usage;
                                    end
                                    if (w_head.is_tap) begin
                                        r_tap_v <= 1'b1;
                                        r_tap_c <= (w_head.consumer != 8'd0);
                                        r_tap_dl <= req.data.now_ms + {24'd0, r_tap_time};
                                    end else begin
                                        r_held_v <= 1'b1;
                                        r_held_c <= (w_head.consumer != 8'd0);
                                        r_held_own <= w_head.owner;
                                        r_held_dl <= req.data.now_ms + {16'd0,
                                            (r_hold_limit != 16'd0) ? r_hold_limit
                                                                    : HOLD_LIMIT_DEF};
                                    end
                                end
                            end
                        end
                        ACT_HOLD, ACT_TAP: if (r_link) begin
                            if (w_full) begin
                                if (r_drops != 16'hFFFF) r_drops <= r_drops + 16'd1;
                            end else begin
                                r_rsp.request_accepted <= 1'b1;
                            end
                        end
                        ACT_REL_OWN: begin
                            if (r_held_v && r_held_own == req.data.owner_id) begin
                                r_up_v <= 1'b1; r_up_c <= r_held_c;
                                r_held_v <= 1'b0; r_held_own <= '0;
                            end else begin
                                r_state <= ST_PURGE;
                            end
                        end
                        ACT_REL_ALL: begin
                            if (r_held_v) begin
                                r_up_v <= 1'b1; r_up_c <= r_held_c;
                                r_held_v <= 1'b0; r_held_own <= '0;
                            end
                            r_state <= ST_PURGE;
                        end
                        ACT_READY: if (req.data.ready_level != r_link) begin
                            r_link <= req.data.ready_level;
                            if (!req.data.ready_level) begin
                                r_tap_v <= 1'b0; r_held_v <= 1'b0;
                                r_held_own <= '0; r_up_v <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_PURGE: begin
                    if (!w_kill_any) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (rsp.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Counters are stable while a result waits
    always_comb begin
        rsp.data = r_rsp;
        rsp.data.dropped_total = r_drops;
        rsp.data.forced_total = r_forces;
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_acc;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    a_purge_only_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PURGE) |-> (r_req.action == ACT_REL_OWN
                                   || r_req.action == ACT_REL_ALL))
        else $error("purge without release");

    a_one_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_held_v && r_tap_v && r_up_v))
        else $error("key state conflict");
endmodule
